FILE: hw/rtl/call_graph_profile_table_top_assert.svh
// Assertion macros for the call graph profile table.
// Used by the controller and the top level; no other dependencies.
`ifndef CALL_GRAPH_PROFILE_TABLE_TOP_ASSERT_SVH
`define CALL_GRAPH_PROFILE_TABLE_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CGP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cgp_pkg.sv
// Shared types and constants for the call graph profile table.
// No dependencies.
`default_nettype none
package cgp_pkg;
    localparam int STACK_DEPTH_DEF   = 64;
    localparam int TABLE_ENTRIES_DEF = 32;

    localparam logic       OP_ENTER = 1'b0;
    localparam logic       OP_EXIT  = 1'b1;
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW  = 2'd2;
    localparam logic [1:0] ST_STACK_FULL = 2'd3;

    typedef struct packed {
        logic        op;
        logic [63:0] func_addr;
        logic [63:0] caller_addr;
        logic [63:0] outer_time;
        logic [63:0] inner_time;
    } t_in;

    typedef struct packed {
        logic [63:0] entry_func;
        logic [63:0] entry_parent;
        logic [31:0] call_count;
        logic [63:0] self_total;
        logic [63:0] shell_total;
        logic [1:0]  status;
        logic        last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture the input transaction
        logic       push;     // write the stack top
        logic       pop_rd;   // read the popped entry and the new top
        logic       lookup;   // compute deltas, parent and register table match
        logic       update;   // write the table entry
        logic       emit_err; // emit error result
        logic [1:0] err_code;
        logic       emit_hit; // emit updated entry
        logic       dump_rd;  // read table slot at dump pointer
        logic       emit_dump;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op;
        logic stack_full;
        logic stack_empty;
        logic pop_to_empty;
        logic table_full;   // no match and no free slot
        logic dump_valid;   // slot at dump pointer is valid
        logic dump_done;    // dump pointer past the last slot
    } t_sts;
endpackage
`default_nettype wire

FILE: hw/rtl/cgp_datapath.sv
// Datapath: call stack memories, profile table, match and dump logic.
// Depends on cgp_pkg.
`default_nettype none
module cgp_datapath import cgp_pkg::*; #(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_out      o_res
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(TABLE_ENTRIES + 1);

    // stack memories (read registered)
    logic [63:0] addr_mem  [STACK_DEPTH];
    logic [63:0] outer_mem [STACK_DEPTH];
    logic [63:0] inner_mem [STACK_DEPTH];

    logic [LW-1:0] r_level;
    t_in           r_in;
    logic [63:0]   r_top_outer, r_top_inner, r_par_addr;
    logic [63:0]   r_self_dt, r_shell_dt, r_parent;
    logic          r_hit_any, r_free_any;
    logic [TW-1:0] r_hit_idx, r_free_idx;
    logic [PW-1:0] r_dptr;

    // table, small enough to keep in flip-flops with per-entry valid
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [63:0] r_kf [TABLE_ENTRIES];
    logic [63:0] r_kp [TABLE_ENTRIES];
    logic [31:0] r_cnt [TABLE_ENTRIES];
    logic [63:0] r_self [TABLE_ENTRIES];
    logic [63:0] r_shell [TABLE_ENTRIES];

    logic [SW-1:0] push_idx, pop_idx, par_idx;
    assign push_idx = r_level[SW-1:0];
    assign pop_idx  = SW'(r_level - LW'(1));
    assign par_idx  = SW'(r_level - LW'(2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        if (i_cmd.push) begin
            addr_mem[push_idx]  <= r_in.func_addr;
            outer_mem[push_idx] <= r_in.outer_time;
            inner_mem[push_idx] <= r_in.inner_time;
        end
        if (i_cmd.pop_rd) begin
            r_top_outer <= outer_mem[pop_idx];
            r_top_inner <= inner_mem[pop_idx];
            r_par_addr  <= addr_mem[par_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.push) begin
            r_level <= r_level + LW'(1);
        end else if (i_cmd.pop_rd) begin
            r_level <= r_level - LW'(1);
        end
    end

    // parent uses level after decrement
    logic [63:0] parent_c;
    assign parent_c = (r_level == '0) ? r_in.caller_addr : r_par_addr;

    logic          hit_any_c, free_any_c;
    logic [TW-1:0] hit_idx_c, free_idx_c;
    always_comb begin
        hit_any_c = 1'b0; free_any_c = 1'b0;
        hit_idx_c = '0;   free_idx_c = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i]) begin
                if (r_kf[i] == r_in.func_addr && r_kp[i] == parent_c) begin
                    hit_any_c = 1'b1;
                    hit_idx_c = TW'(i);
                end
            end else begin
                free_any_c = 1'b1;
                free_idx_c = TW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_self_dt  <= r_in.inner_time - r_top_inner;
            r_shell_dt <= r_in.outer_time - r_top_outer;
            r_parent   <= parent_c;
            r_hit_any  <= hit_any_c;
            r_free_any <= free_any_c;
            r_hit_idx  <= hit_idx_c;
            r_free_idx <= free_idx_c;
        end
    end

    logic [TW-1:0] upd_idx;
    assign upd_idx = r_hit_any ? r_hit_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (r_hit_any) begin
                if (r_cnt[upd_idx] != 32'hFFFF_FFFF) r_cnt[upd_idx] <= r_cnt[upd_idx] + 32'd1;
                r_self[upd_idx]  <= r_self[upd_idx] + r_self_dt;
                r_shell[upd_idx] <= r_shell[upd_idx] + r_shell_dt;
            end else begin
                r_kf[upd_idx]    <= r_in.func_addr;
                r_kp[upd_idx]    <= r_parent;
                r_cnt[upd_idx]   <= 32'd1;
                r_self[upd_idx]  <= r_self_dt;
                r_shell[upd_idx] <= r_shell_dt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.update) begin
            r_valid[upd_idx] <= 1'b1;
        end
    end

    // dump pointer: scan slots one a cycle
    logic [TW-1:0] dptr_idx;
    assign dptr_idx = r_dptr[TW-1:0];
    logic          more_valid;
    always_comb begin
        more_valid = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (PW'(i) > r_dptr && r_valid[i]) more_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dptr <= '0;
        end else if (i_cmd.update) begin
            r_dptr <= '0;
        end else if (i_cmd.dump_rd) begin
            r_dptr <= r_dptr + PW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            o_res.entry_func   <= r_in.func_addr;
            o_res.entry_parent <= i_cmd.err_code == ST_TABLE_FULL ? r_parent
                                                                   : r_in.caller_addr;
            o_res.call_count   <= '0;
            o_res.self_total   <= '0;
            o_res.shell_total  <= '0;
            o_res.status       <= i_cmd.err_code;
            o_res.last         <= 1'b1;
        end else if (i_cmd.emit_hit || i_cmd.emit_dump) begin
            o_res.entry_func   <= r_kf[i_cmd.emit_hit ? upd_idx : dptr_idx];
            o_res.entry_parent <= r_kp[i_cmd.emit_hit ? upd_idx : dptr_idx];
            o_res.call_count   <= r_cnt[i_cmd.emit_hit ? upd_idx : dptr_idx];
            o_res.self_total   <= r_self[i_cmd.emit_hit ? upd_idx : dptr_idx];
            o_res.shell_total  <= r_shell[i_cmd.emit_hit ? upd_idx : dptr_idx];
            o_res.status       <= ST_OK;
            o_res.last         <= i_cmd.emit_hit | ~more_valid;
        end
    end

    assign o_sts.op           = r_in.op;
    assign o_sts.stack_full   = (r_level == LW'(STACK_DEPTH));
    assign o_sts.stack_empty  = (r_level == '0);
    assign o_sts.pop_to_empty = (r_level == '0);
    assign o_sts.table_full   = ~r_hit_any & ~r_free_any;
    assign o_sts.dump_valid   = (r_dptr < PW'(TABLE_ENTRIES)) && r_valid[dptr_idx];
    assign o_sts.dump_done    = (r_dptr >= PW'(TABLE_ENTRIES));
endmodule
`default_nettype wire

FILE: hw/rtl/cgp_ctrl.sv
// Controller state machine sequencing push, pop, lookup, update and dump.
// Depends on cgp_pkg and the assertion macro header.
`default_nettype none
`include "call_graph_profile_table_top_assert.svh"
module cgp_ctrl import cgp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output logic      o_busy,
    output logic      o_load,
    output t_cmd      o_cmd,
    output logic      o_strobe
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_LOOK = 3'd2,
                           S_UPD = 3'd3, S_EMIT = 3'd4, S_DUMP = 3'd5, S_OUT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_strobe, n_strobe;
    logic       r_dumping, n_dumping;

    assign o_busy = (r_state != S_IDLE);
    assign o_load = i_start && !o_busy;
    assign o_strobe = r_strobe;

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_dumping = r_dumping;
        o_cmd     = '0;
        o_cmd.load = o_load;
        unique case (r_state)
            S_IDLE: begin
                if (o_load) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.op == OP_ENTER) begin
                    if (i_sts.stack_full) begin
                        o_cmd.emit_err = 1'b1; o_cmd.err_code = ST_STACK_FULL;
                        n_strobe = 1'b1; n_state = S_OUT;
                    end else begin
                        o_cmd.push = 1'b1; n_state = S_IDLE;
                    end
                end else if (i_sts.stack_empty) begin
                    o_cmd.emit_err = 1'b1; o_cmd.err_code = ST_UNDERFLOW;
                    n_strobe = 1'b1; n_state = S_OUT;
                end else begin
                    o_cmd.pop_rd = 1'b1; n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1; n_state = S_UPD;
            end
            S_UPD: begin
                if (i_sts.table_full) begin
                    o_cmd.emit_err = 1'b1; o_cmd.err_code = ST_TABLE_FULL;
                    n_strobe = 1'b1; n_state = S_OUT;
                end else begin
                    o_cmd.update = 1'b1;
                    n_dumping = i_sts.pop_to_empty;
                    n_state = i_sts.pop_to_empty ? S_DUMP : S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_hit = 1'b1; n_strobe = 1'b1; n_state = S_OUT;
            end
            S_DUMP: begin
                if (i_sts.dump_done) begin
                    n_dumping = 1'b0; n_state = S_IDLE;
                end else begin
                    o_cmd.dump_rd = 1'b1;
                    if (i_sts.dump_valid) begin
                        o_cmd.emit_dump = 1'b1; n_strobe = 1'b1;
                    end
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_strobe <= 1'b0; r_dumping <= 1'b0;
        end else begin
            r_state <= n_state; r_strobe <= n_strobe; r_dumping <= n_dumping;
        end
    end

    `CGP_ASSERT_IMP(a_load_idle, i_clk, i_rst_n, o_load, r_state == S_IDLE, "load while busy")
    `CGP_ASSERT_NEXT(a_err_strobe, i_clk, i_rst_n, o_cmd.emit_err, r_strobe, "error not strobed")
    `CGP_ASSERT_IMP(a_dump_flag, i_clk, i_rst_n, r_state == S_DUMP, r_dumping, "dump w/o flag")
endmodule
`default_nettype wire

FILE: hw/rtl/call_graph_profile_table_top.sv
// Top level of the call graph profile table.
// Depends on cgp_pkg, cgp_ctrl, cgp_datapath and the assertion macro header.
//
// Usage: drive i_item and raise start; the transaction is accepted on a rising
// edge where start is high and busy is low. Results appear on o_result, each
// marked by o_strobe high for exactly one cycle; the receiver cannot stall them.
// An enter gives no result. On a full stack the error result is on o_result
// in the cycle after acceptance; an underflow exit behaves the same. An exit
// has its updated entry on o_result after the stack read, the registered table
// match, the table write and the result register; a table-full result comes
// from the result register after the registered table match, in place of the
// table write.
// When the stack empties, the table is scanned one slot a cycle while busy
// stays high; o_result.last marks the final result.
// busy stays high until the transaction's last result has gone out.
// Reset (synchronous, active low) empties the stack and clears all table
// valid bits at once; no clearing pass is needed.
`default_nettype none
`include "call_graph_profile_table_top_assert.svh"
module call_graph_profile_table_top import cgp_pkg::*; #(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_item,
    output logic      o_strobe,
    output t_out      o_result
);
    t_cmd cmd;
    t_sts sts;
    logic load;

    // hold sequencing in the controller, the storage in the datapath
    cgp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(sts),
        .o_busy(busy), .o_load(load), .o_cmd(cmd), .o_strobe(o_strobe)
    );

    cgp_datapath #(.STACK_DEPTH(STACK_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(cmd),
        .o_sts(sts), .o_res(o_result)
    );

    `CGP_ASSERT_IMP(a_load_match, i_clk, i_rst_n, load, start && !busy, "bad load")
    `CGP_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, load, busy, "not busy after accept")
    `CGP_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe && !o_result.last, busy, "dump idle")
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the call graph profile table.
// Depends on cgp_pkg and call_graph_profile_table_top; a small scoreboard class
// predicts the table updates, dumps and error reports of each transaction.
`timescale 1ns / 100ps

class profile_scoreboard;
    localparam int DEPTH   = cgp_pkg::STACK_DEPTH_DEF;
    localparam int ENTRIES = cgp_pkg::TABLE_ENTRIES_DEF;

    logic [63:0] call_addr [DEPTH];
    logic [63:0] call_outer[DEPTH];
    logic [63:0] call_inner[DEPTH];
    int          call_level;
    bit          slot_used [ENTRIES];
    logic [63:0] slot_func  [ENTRIES];
    logic [63:0] slot_parent[ENTRIES];
    logic [31:0] slot_count [ENTRIES];
    logic [63:0] slot_self  [ENTRIES];
    logic [63:0] slot_shell [ENTRIES];
    cgp_pkg::t_out pending[$];
    int errors;
    int checked;

    function new();
        call_level = 0;
        errors = 0;
        checked = 0;
        foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function int used_slots();
        int n;
        n = 0;
        foreach (slot_used[i]) if (slot_used[i]) n++;
        return n;
    endfunction

    function void push_result(logic [63:0] f, logic [63:0] p, logic [31:0] c,
                              logic [63:0] s, logic [63:0] sh, logic [1:0] st,
                              logic lst);
        cgp_pkg::t_out r;
        r.entry_func = f;
        r.entry_parent = p;
        r.call_count = c;
        r.self_total = s;
        r.shell_total = sh;
        r.status = st;
        r.last = lst;
        pending.push_back(r);
    endfunction

    // Note an accepted transaction and queue the results it must cause.
    function void note_event(cgp_pkg::t_in it);
        logic [63:0] self_dt, shell_dt, parent;
        int hit, free_idx, last_idx;
        hit = -1;
        free_idx = -1;
        last_idx = 0;
        if (it.op == cgp_pkg::OP_ENTER) begin
            if (call_level >= DEPTH) begin
                push_result(it.func_addr, it.caller_addr, 0, 0, 0,
                            cgp_pkg::ST_STACK_FULL, 1'b1);
                return;
            end
            call_addr[call_level] = it.func_addr;
            call_outer[call_level] = it.outer_time;
            call_inner[call_level] = it.inner_time;
            call_level++;
            return;
        end
        if (call_level == 0) begin
            push_result(it.func_addr, it.caller_addr, 0, 0, 0,
                        cgp_pkg::ST_UNDERFLOW, 1'b1);
            return;
        end
        call_level--;
        self_dt = it.inner_time - call_inner[call_level];
        shell_dt = it.outer_time - call_outer[call_level];
        parent = (call_level == 0) ? it.caller_addr : call_addr[call_level - 1];
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i]) begin
                if (hit < 0 && slot_func[i] == it.func_addr && slot_parent[i] == parent)
                    hit = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (hit < 0) begin
            if (free_idx < 0) begin
                push_result(it.func_addr, parent, 0, 0, 0, cgp_pkg::ST_TABLE_FULL, 1'b1);
                return;
            end
            hit = free_idx;
            slot_used[hit] = 1;
            slot_func[hit] = it.func_addr;
            slot_parent[hit] = parent;
            slot_count[hit] = 1;
            slot_self[hit] = self_dt;
            slot_shell[hit] = shell_dt;
        end else begin
            if (slot_count[hit] != 32'hFFFF_FFFF) slot_count[hit]++;
            slot_self[hit] += self_dt;
            slot_shell[hit] += shell_dt;
        end
        if (call_level != 0) begin
            push_result(slot_func[hit], slot_parent[hit], slot_count[hit],
                        slot_self[hit], slot_shell[hit], cgp_pkg::ST_OK, 1'b1);
            return;
        end
        for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) last_idx = i;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
                push_result(slot_func[i], slot_parent[i], slot_count[i], slot_self[i],
                            slot_shell[i], cgp_pkg::ST_OK, i == last_idx);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 30)
            $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
    endtask

    task check_result(cgp_pkg::t_out r);
        cgp_pkg::t_out e;
        checked++;
        if (pending.size() == 0) begin
            report("unexpected result", r.entry_func, 0);
            return;
        end
        e = pending.pop_front();
        if (r.entry_func !== e.entry_func) report("entry_func", r.entry_func, e.entry_func);
        if (r.entry_parent !== e.entry_parent)
            report("entry_parent", r.entry_parent, e.entry_parent);
        if (r.call_count !== e.call_count) report("call_count", r.call_count, e.call_count);
        if (r.self_total !== e.self_total) report("self_total", r.self_total, e.self_total);
        if (r.shell_total !== e.shell_total)
            report("shell_total", r.shell_total, e.shell_total);
        if (r.status !== e.status) report("status", r.status, e.status);
        if (r.last !== e.last) report("last", r.last, e.last);
    endtask
endclass

module tb;
    import cgp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int STACK_LEVELS = STACK_DEPTH_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_item = '0;
    logic o_strobe;
    t_out o_result;

    profile_scoreboard board = new();
    int sender_idle_pct = 28;
    int idle_cycles = 0;
    int sent = 0;
    bit timed_out = 0;
    logic [63:0] clock_now = 64'd1000;

    call_graph_profile_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    // Check every strobed result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_result(o_result);
        end
    end

    // Watchdog: count cycles in which no transaction moves either way.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("Watchdog expired with %0d results outstanding",
                         board.pending.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Drive one transaction at a falling edge where busy is low, so the next
    // rising edge takes it.
    task automatic send_event(logic opc, logic [63:0] f, logic [63:0] c,
                              logic [63:0] ot, logic [63:0] it);
        t_in x;
        x.op = opc;
        x.func_addr = f;
        x.caller_addr = c;
        x.outer_time = ot;
        x.inner_time = it;
        while (busy || $urandom_range(99) < sender_idle_pct) @(negedge i_clk);
        start <= 1'b1;
        i_item <= x;
        @(posedge i_clk);
        board.note_event(x);
        sent++;
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Pick from a small pool of addresses so pairs repeat and hit the table.
    function automatic logic [63:0] pick_func();
        if ($urandom_range(9) == 0) return rand64();
        return 64'h4000_0000 + 64'($urandom_range(11)) * 64'h40;
    endfunction

    task automatic enter_now(logic [63:0] f);
        clock_now += 64'($urandom_range(200));
        send_event(OP_ENTER, f, rand64(), clock_now, clock_now - 64'($urandom_range(50)));
    endtask

    task automatic exit_now(logic [63:0] f);
        clock_now += 64'($urandom_range(200));
        send_event(OP_EXIT, f, pick_func(), clock_now, clock_now - 64'($urandom_range(50)));
    endtask

    // One well-formed call tree with random shape; closes every frame it opens.
    task automatic call_tree(int max_depth);
        int level;
        level = 0;
        enter_now(pick_func());
        level = 1;
        while (level > 0) begin
            if (level < max_depth && $urandom_range(1)) begin
                enter_now(pick_func());
                level++;
            end else begin
                exit_now(pick_func());
                level--;
            end
        end
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0 || busy) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: underflow on an empty stack, extreme field values.
        send_event(OP_EXIT, '1, '0, '1, '0);
        send_event(OP_EXIT, '0, '1, '0, '1);
        // Times that wrap, then an exit to a nonempty stack and an emptying one.
        send_event(OP_ENTER, '1, '0, '1, '1);
        send_event(OP_ENTER, '0, '1, '1, '1);
        send_event(OP_EXIT, '1, '1, '0, '0);
        send_event(OP_EXIT, '0, '0, '0, '0);
        // A new pair (parent zero from the caller address), so a new entry is made.
        send_event(OP_ENTER, '1, '0, 64'd5, 64'd7);
        send_event(OP_EXIT, '1, '0, 64'd4, 64'd3);
        // Exit names a different function than the stack top.
        send_event(OP_ENTER, 64'h1234, 64'h55, 64'd10, 64'd10);
        send_event(OP_EXIT, 64'h9999, 64'h66, 64'd20, 64'd30);

        // Random call trees in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            int goal;
            sender_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 73 : 0;
            goal = sent + 60;
            while (sent < goal) begin
                if ($urandom_range(9) == 0) begin
                    // noise: a stray exit or a lone random event
                    send_event(1'($urandom_range(1)), rand64(), rand64(), rand64(),
                               rand64());
                end else begin
                    call_tree(int'($urandom_range(2, 6)));
                end
            end
            // Close any open frames left by noise.
            while (board.call_level > 0) exit_now(pick_func());
        end
        wait_drained();

        // Fill the stack past its depth to cause stack-full drops.
        for (int i = 0; i < STACK_LEVELS + 2; i++)
            send_event(OP_ENTER, 64'h7000 + 64'(i), rand64(), 64'(i), 64'(i));
        // Unwind, each level a new pair, which also overflows the table.
        for (int i = 0; i < STACK_LEVELS; i++)
            send_event(OP_EXIT, 64'h7000 + 64'(STACK_LEVELS - 1 - i),
                       rand64(), 64'(1000 + i), 64'(2000 + i));

        wait_drained();
        $display("Sent %0d transactions, checked %0d results, %0d table slots in use.",
                 sent, board.checked, board.used_slots());
        $display("Covered underflow, stack-full and table-full drops, hits and dumps.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
